FILE: sv/cbmm_pkg.sv
// Shared types, constants and helper functions for the console bus memory map decoder.
// Depends on nothing; cbmm_decode, console_bus_memory_map and the testbench import it.
package cbmm_pkg;

    localparam int RAM_ADDR_BITS      = 21;
    localparam int ROM_ADDR_BITS      = 19;
    localparam int SCRATCH_ADDR_BITS  = 10;
    localparam int PARALLEL_ADDR_BITS = 16;

    localparam int RAM_WBITS = RAM_ADDR_BITS - 2;
    localparam int ROM_WBITS = ROM_ADDR_BITS - 2;
    localparam int SCR_WBITS = SCRATCH_ADDR_BITS - 2;
    localparam int PAR_WBITS = PARALLEL_ADDR_BITS - 2;

    localparam int CLR_BITS_A = (RAM_WBITS > PAR_WBITS) ? RAM_WBITS : PAR_WBITS;
    localparam int CLR_BITS   = (CLR_BITS_A > SCR_WBITS) ? CLR_BITS_A : SCR_WBITS;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [15:0] PG_SCR0  = 16'h1F80;
    localparam logic [15:0] PG_SCR1  = 16'h9F80;
    localparam logic [15:0] PG_SCR2  = 16'hBF80;
    localparam logic [15:0] PG_PAR   = 16'h1F00;
    localparam logic [8:0]  RAM_SEG0 = 9'h000;
    localparam logic [8:0]  RAM_SEG1 = 9'h100;
    localparam logic [8:0]  RAM_SEG2 = 9'h140;
    localparam logic [12:0] ROM_SEG0 = 13'h03F8;
    localparam logic [12:0] ROM_SEG1 = 13'h13F8;
    localparam logic [12:0] ROM_SEG2 = 13'h17F8;

    localparam logic [31:0] CACHE_CTRL_ADDR = 32'hFFFE0130;
    localparam logic [31:0] ISOLATE_A       = 32'h0000_0800;
    localparam logic [31:0] ISOLATE_B       = 32'h0000_0804;
    localparam logic [31:0] RELEASE_A       = 32'h0000_0000;
    localparam logic [31:0] RELEASE_B       = 32'h0001_E988;

    typedef enum logic [2:0] {
        ROUTE_RAM   = 3'd0,
        ROUTE_PAR   = 3'd1,
        ROUTE_SCR   = 3'd2,
        ROUTE_BIOS  = 3'd3,
        ROUTE_HW    = 3'd4,
        ROUTE_NONE  = 3'd5,
        ROUTE_CACHE = 3'd6
    } route_t;

    typedef struct packed {
        logic ram_en;
        logic par_en;
        logic scr_en;
        logic rom_en;
        logic [3:0] be;
    } mem_req_t;

    typedef struct packed {
        route_t     route;
        logic [1:0] lane;
        logic [1:0] size;
        logic       rd;
        logic       dropped;
        logic       inval;
    } acc_info_t;

    function automatic logic [31:0] size_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_HALF: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/console_bus_memory_map.sv
// Console bus memory map decoder: s_ channel takes bus accesses, m_ channel returns results.
// The block holds main RAM, parallel port RAM, scratchpad and BIOS ROM in synchronous memories.
// One transfer in gives one transfer out, in order, with zero-extended little-endian read data.
// An accepted transfer goes through the memory read, with its details held in the read stage,
// then through lane alignment into the output register that drives m_valid.
// Throughput is one access per cycle while s_ready is high; the single port of each memory
// takes one access a cycle and a write lands before the next access reads the same word.
// After reset a clearing pass zeroes main, parallel and scratchpad RAM, one word of each
// per cycle, over all 2^(RAM_ADDR_BITS-2) main RAM words (524288 at the default size);
// s_ready stays low until it ends. The BIOS ROM is not cleared: cmd 2 loads it word by word.
// Reset also ends cache isolation.
// When the receiver holds m_ready low, the result waits in the output register, one more
// access may sit in the read stage, and s_ready then drops until the output drains.
// Depends on cbmm_pkg, cbmm_decode and cbmm_ram.
module console_bus_memory_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [1:0]  s_access_size,
    input  logic [31:0] s_address,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic [2:0]  m_route,
    output logic        m_write_dropped,
    output logic        m_icache_invalidate
);
    import cbmm_pkg::*;

    logic                 accept;
    mem_req_t             req;
    acc_info_t            info;
    logic [RAM_WBITS-1:0] dec_ram_idx;
    logic [PAR_WBITS-1:0] dec_par_idx;
    logic [SCR_WBITS-1:0] dec_scr_idx;
    logic [ROM_WBITS-1:0] dec_rom_idx;
    logic [31:0]          dec_wdata;

    logic                 clr_busy_reg;
    logic [CLR_BITS-1:0]  clr_idx_reg;

    logic                 ram_en, par_en, scr_en, rom_en;
    logic [3:0]           ram_we, par_we, scr_we, rom_we;
    logic [RAM_WBITS-1:0] ram_addr;
    logic [PAR_WBITS-1:0] par_addr;
    logic [SCR_WBITS-1:0] scr_addr;
    logic [31:0]          mem_wdata;
    logic [31:0]          ram_rdata, par_rdata, scr_rdata, rom_rdata;

    logic                 p1_valid_reg;
    logic                 p1_valid_next;
    acc_info_t            p1_info_reg;
    logic                 out_free;
    logic [31:0]          word_sel;
    logic [31:0]          rd_aligned;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [31:0]          m_read_data_reg;
    route_t               m_route_reg;
    logic                 m_write_dropped_reg;
    logic                 m_icache_invalidate_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !clr_busy_reg && (!p1_valid_reg || out_free);
    assign accept   = s_valid && s_ready;

    cbmm_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (s_cmd),
        .access_size (s_access_size),
        .address     (s_address),
        .write_data  (s_write_data),
        .req         (req),
        .info        (info),
        .ram_idx     (dec_ram_idx),
        .par_idx     (dec_par_idx),
        .scr_idx     (dec_scr_idx),
        .rom_idx     (dec_rom_idx),
        .wdata       (dec_wdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == {CLR_BITS{1'b1}}) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (clr_busy_reg) begin
            ram_en    = 1'b1;
            par_en    = 1'b1;
            scr_en    = 1'b1;
            ram_we    = 4'b1111;
            par_we    = 4'b1111;
            scr_we    = 4'b1111;
            ram_addr  = clr_idx_reg[RAM_WBITS-1:0];
            par_addr  = clr_idx_reg[PAR_WBITS-1:0];
            scr_addr  = clr_idx_reg[SCR_WBITS-1:0];
            mem_wdata = '0;
        end else begin
            ram_en    = accept && req.ram_en;
            par_en    = accept && req.par_en;
            scr_en    = accept && req.scr_en;
            ram_we    = req.be;
            par_we    = req.be;
            scr_we    = req.be;
            ram_addr  = dec_ram_idx;
            par_addr  = dec_par_idx;
            scr_addr  = dec_scr_idx;
            mem_wdata = dec_wdata;
        end
        rom_en = accept && req.rom_en;
        rom_we = req.be;
    end

    cbmm_ram #(.ADDR_BITS(RAM_WBITS)) u_main_ram (
        .aclk (aclk), .en (ram_en), .we (ram_we), .addr (ram_addr),
        .wdata (mem_wdata), .rdata (ram_rdata)
    );

    cbmm_ram #(.ADDR_BITS(PAR_WBITS)) u_parallel_ram (
        .aclk (aclk), .en (par_en), .we (par_we), .addr (par_addr),
        .wdata (mem_wdata), .rdata (par_rdata)
    );

    cbmm_ram #(.ADDR_BITS(SCR_WBITS)) u_scratch_ram (
        .aclk (aclk), .en (scr_en), .we (scr_we), .addr (scr_addr),
        .wdata (mem_wdata), .rdata (scr_rdata)
    );

    cbmm_ram #(.ADDR_BITS(ROM_WBITS)) u_bios_rom (
        .aclk (aclk), .en (rom_en), .we (rom_we), .addr (dec_rom_idx),
        .wdata (dec_wdata), .rdata (rom_rdata)
    );

    always_comb begin
        case (p1_info_reg.route)
            ROUTE_RAM:  word_sel = ram_rdata;
            ROUTE_PAR:  word_sel = par_rdata;
            ROUTE_SCR:  word_sel = scr_rdata;
            ROUTE_BIOS: word_sel = rom_rdata;
            default:    word_sel = '0;
        endcase
        rd_aligned = p1_info_reg.rd
                   ? ((word_sel >> {p1_info_reg.lane, 3'b000}) & size_mask(p1_info_reg.size))
                   : 32'd0;
    end

    always_comb begin
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (out_free) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
        m_valid_next = out_free ? p1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_info_reg <= info;
        end
        if (out_free && p1_valid_reg) begin
            m_read_data_reg         <= rd_aligned;
            m_route_reg             <= p1_info_reg.route;
            m_write_dropped_reg     <= p1_info_reg.dropped;
            m_icache_invalidate_reg <= p1_info_reg.inval;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_read_data         = m_read_data_reg;
    assign m_route             = m_route_reg;
    assign m_write_dropped     = m_write_dropped_reg;
    assign m_icache_invalidate = m_icache_invalidate_reg;

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready)
        else $error("Input accepted during the clearing pass.");

    a_inval_only_on_cache_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_icache_invalidate_reg) |-> (m_route_reg == ROUTE_CACHE))
        else $error("Cache invalidate pulse on a route other than cache control.");

    a_drop_routes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_write_dropped_reg) |->
        (m_route_reg == ROUTE_RAM || m_route_reg == ROUTE_BIOS || m_route_reg == ROUTE_NONE))
        else $error("Dropped write reported on a route that never drops.");

    a_read_data_routes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_read_data_reg != 32'd0) |->
        (m_route_reg == ROUTE_RAM || m_route_reg == ROUTE_PAR ||
         m_route_reg == ROUTE_SCR || m_route_reg == ROUTE_BIOS))
        else $error("Nonzero read data from a route without storage.");

    a_stage_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && out_free) |=> m_valid_reg)
        else $error("Read stage advanced without filling the output register.");

endmodule

FILE: sv/cbmm_ram.sv
// Generic single-port synchronous RAM with byte write enables and a registered read.
// Depends on nothing.
module cbmm_ram #(
    parameter int ADDR_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [3:0]           we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [31:0]          wdata,
    output logic [31:0]          rdata
);

    logic [31:0] mem [2**ADDR_BITS];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                if (we[i]) begin
                    mem[addr][8*i +: 8] <= wdata[8*i +: 8];
                end
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/cbmm_decode.sv
// Address decoder for one bus access; holds the cache isolation flag.
// Depends on cbmm_pkg.
module cbmm_decode (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [1:0]                      cmd,
    input  logic [1:0]                      access_size,
    input  logic [31:0]                     address,
    input  logic [31:0]                     write_data,
    output cbmm_pkg::mem_req_t              req,
    output cbmm_pkg::acc_info_t             info,
    output logic [cbmm_pkg::RAM_WBITS-1:0]  ram_idx,
    output logic [cbmm_pkg::PAR_WBITS-1:0]  par_idx,
    output logic [cbmm_pkg::SCR_WBITS-1:0]  scr_idx,
    output logic [cbmm_pkg::ROM_WBITS-1:0]  rom_idx,
    output logic [31:0]                     wdata
);
    import cbmm_pkg::*;

    logic        isolated_reg;
    logic        isolated_next;
    logic        wr;
    logic        load;
    logic [1:0]  size;
    logic [31:0] addr_al;
    logic [15:0] page;
    logic [15:0] off;
    logic [31:0] data_m;
    logic [3:0]  be_sz;
    logic [22:0] ram_ba;
    logic [18:0] rom_ba;
    logic        scr_page;
    logic        scr_low;
    logic        ram_hit;
    logic        par_hit;
    logic        rom_hit;
    logic        cache_hit;

    always_comb begin
        case (access_size)
            SIZE_BYTE: begin
                size    = SIZE_BYTE;
                addr_al = address;
                be_sz   = 4'b0001;
            end
            SIZE_HALF: begin
                size    = SIZE_HALF;
                addr_al = {address[31:1], 1'b0};
                be_sz   = 4'b0011;
            end
            default: begin
                size    = SIZE_WORD;
                addr_al = {address[31:2], 2'b00};
                be_sz   = 4'b1111;
            end
        endcase
    end

    assign load      = (cmd == CMD_LOAD);
    assign wr        = (cmd == CMD_WRITE);
    assign page      = addr_al[31:16];
    assign off       = addr_al[15:0];
    assign data_m    = write_data & size_mask(size);
    assign ram_ba    = {page[6:0], off};
    assign rom_ba    = {page[2:0], off};
    assign scr_page  = page inside {PG_SCR0, PG_SCR1, PG_SCR2};
    assign scr_low   = ((32'(off) >> SCRATCH_ADDR_BITS) == 32'd0);
    assign ram_hit   = page[15:7] inside {RAM_SEG0, RAM_SEG1, RAM_SEG2};
    assign par_hit   = (page == PG_PAR);
    assign rom_hit   = page[15:3] inside {ROM_SEG0, ROM_SEG1, ROM_SEG2};
    assign cache_hit = wr && (size == SIZE_WORD) && (addr_al == CACHE_CTRL_ADDR);

    assign ram_idx = ram_ba[RAM_ADDR_BITS-1:2];
    assign par_idx = off[PARALLEL_ADDR_BITS-1:2];
    assign scr_idx = off[SCRATCH_ADDR_BITS-1:2];
    assign rom_idx = load ? address[ROM_ADDR_BITS-1:2] : rom_ba[ROM_ADDR_BITS-1:2];
    assign wdata   = load ? write_data : (data_m << {addr_al[1:0], 3'b000});

    always_comb begin
        req           = '0;
        info          = '0;
        info.route    = ROUTE_NONE;
        info.lane     = addr_al[1:0];
        info.size     = size;
        isolated_next = isolated_reg;
        if (load) begin
            info.route = ROUTE_BIOS;
            req.rom_en = 1'b1;
            req.be     = 4'b1111;
        end else if (scr_page) begin
            if (scr_low) begin
                info.route = ROUTE_SCR;
                info.rd    = !wr;
                req.scr_en = 1'b1;
                req.be     = wr ? (be_sz << addr_al[1:0]) : 4'b0000;
            end else begin
                info.route = ROUTE_HW;
            end
        end else if (ram_hit) begin
            info.route   = ROUTE_RAM;
            info.rd      = !wr;
            info.dropped = wr && isolated_reg;
            req.ram_en   = !(wr && isolated_reg);
            req.be       = wr ? (be_sz << addr_al[1:0]) : 4'b0000;
        end else if (par_hit) begin
            info.route = ROUTE_PAR;
            info.rd    = !wr;
            req.par_en = 1'b1;
            req.be     = wr ? (be_sz << addr_al[1:0]) : 4'b0000;
        end else if (rom_hit) begin
            info.route   = ROUTE_BIOS;
            info.rd      = !wr;
            info.dropped = wr;
            req.rom_en   = !wr;
        end else if (cache_hit) begin
            info.route = ROUTE_CACHE;
            if (data_m == ISOLATE_A || data_m == ISOLATE_B) begin
                info.inval    = !isolated_reg;
                isolated_next = 1'b1;
            end else if (data_m == RELEASE_A || data_m == RELEASE_B) begin
                isolated_next = 1'b0;
            end
        end else begin
            info.dropped = wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isolated_reg <= 1'b0;
        end else if (accept) begin
            isolated_reg <= isolated_next;
        end
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the console bus memory map decoder (console_bus_memory_map).
// A queued driver and a checking monitor run against an in-bench predictor of every memory
// region and the cache isolation state. Depends on cbmm_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbmm_pkg::*;

    localparam logic [1:0] CMD_READ_ALT  = 2'd3;
    localparam logic [1:0] SIZE_WORD_ALT = 2'd3;

    localparam logic [15:0] PG_RAM1  = 16'h8000;
    localparam logic [15:0] PG_RAM2  = 16'hA000;
    localparam logic [15:0] PG_BIOS0 = 16'h1FC0;
    localparam logic [15:0] PG_BIOS1 = 16'h9FC0;
    localparam logic [15:0] PG_BIOS2 = 16'hBFC0;

    localparam int RANDOM_ITEMS = 1550;
    localparam int QUIET_TAIL   = 150;
    localparam int RAM_POOL     = 32;
    localparam int ROM_POOL     = 48;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  size;
        logic [31:0] address;
        logic [31:0] data;
    } bus_access_t;

    typedef struct packed {
        logic [31:0] read_data;
        route_t      route;
        logic        dropped;
        logic        inval;
    } bus_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_READ;
    logic [1:0]  s_access_size = SIZE_BYTE;
    logic [31:0] s_address = 32'h0;
    logic [31:0] s_write_data = 32'h0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic [2:0]  m_route;
    logic        m_write_dropped;
    logic        m_icache_invalidate;

    console_bus_memory_map DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_access_size       (s_access_size),
        .s_address           (s_address),
        .s_write_data        (s_write_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_read_data         (m_read_data),
        .m_route             (m_route),
        .m_write_dropped     (m_write_dropped),
        .m_icache_invalidate (m_icache_invalidate)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    bit [31:0] main_words    [1 << RAM_WBITS];
    bit [31:0] parallel_words[1 << PAR_WBITS];
    bit [31:0] scratch_words [1 << SCR_WBITS];
    bit [31:0] bios_words    [1 << ROM_WBITS];
    bit        isolated = 1'b0;

    bus_access_t access_q[$];
    bus_result_t result_q[$];
    bit          bios_loaded[int unsigned];
    int unsigned loaded_list[$];

    int unsigned total_items = 32'hFFFF_FFFF;
    int unsigned pause_a = 0;
    int unsigned pause_b = 0;
    int unsigned popped = 0;
    int unsigned sent = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned results_seen = 0;
    int unsigned error_count = 0;

    wire quiet = (popped + QUIET_TAIL >= total_items);

    function automatic bit is_bios_page(input logic [15:0] pg);
        return (pg & 16'hFFF8) == PG_BIOS0 || (pg & 16'hFFF8) == PG_BIOS1 ||
               (pg & 16'hFFF8) == PG_BIOS2;
    endfunction

    function automatic int unsigned bios_cpu_index(input logic [31:0] address);
        return (((address[18:16] << 16) | address[15:0]) & ((1 << ROM_ADDR_BITS) - 1)) >> 2;
    endfunction

    function automatic logic [15:0] pick_page(input logic [15:0] p0, p1, p2);
        case ($urandom_range(0, 2))
            0:       return p0;
            1:       return p1;
            default: return p2;
        endcase
    endfunction

    function automatic logic [31:0] lane_read(input logic [31:0] word, input int unsigned sh,
                                              input logic [31:0] mask);
        return (word >> sh) & mask;
    endfunction

    function automatic logic [31:0] lane_merge(input logic [31:0] word, data,
                                               input int unsigned sh, input logic [31:0] mask);
        return (word & ~(mask << sh)) | ((data << sh) & (mask << sh));
    endfunction

    function automatic void predict_result(input logic [1:0] cmd, size,
                                           input logic [31:0] address, data);
        bus_result_t res;
        int unsigned nbytes, sh, idx;
        logic [31:0] a, d, mask;
        logic [15:0] pg, off;
        bit wr;
        res = '{read_data: 32'h0, route: ROUTE_NONE, dropped: 1'b0, inval: 1'b0};
        wr = (cmd == CMD_WRITE);
        nbytes = (size == SIZE_BYTE) ? 1 : (size == SIZE_HALF) ? 2 : 4;
        mask = (nbytes == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 1);
        if (cmd == CMD_LOAD) begin
            bios_words[(address >> 2) & ((1 << ROM_WBITS) - 1)] = data;
            res.route = ROUTE_BIOS;
        end else begin
            a = address & ~(nbytes - 1);
            pg = a[31:16];
            off = a[15:0];
            d = data & mask;
            sh = 8 * a[1:0];
            if (pg == PG_SCR0 || pg == PG_SCR1 || pg == PG_SCR2) begin
                if ((off >> SCRATCH_ADDR_BITS) == 0) begin
                    res.route = ROUTE_SCR;
                    idx = (off >> 2) & ((1 << SCR_WBITS) - 1);
                    if (wr) scratch_words[idx] = lane_merge(scratch_words[idx], d, sh, mask);
                    else res.read_data = lane_read(scratch_words[idx], sh, mask);
                end else begin
                    res.route = ROUTE_HW;
                end
            end else if ((pg & 16'hFF80) == 16'h0000 || (pg & 16'hFF80) == PG_RAM1 ||
                         (pg & 16'hFF80) == PG_RAM2) begin
                res.route = ROUTE_RAM;
                idx = ((((pg & 16'h7F) << 16) | off) & ((1 << RAM_ADDR_BITS) - 1)) >> 2;
                if (wr) begin
                    if (isolated) res.dropped = 1'b1;
                    else main_words[idx] = lane_merge(main_words[idx], d, sh, mask);
                end else begin
                    res.read_data = lane_read(main_words[idx], sh, mask);
                end
            end else if (pg == PG_PAR) begin
                res.route = ROUTE_PAR;
                idx = (off >> 2) & ((1 << PAR_WBITS) - 1);
                if (wr) parallel_words[idx] = lane_merge(parallel_words[idx], d, sh, mask);
                else res.read_data = lane_read(parallel_words[idx], sh, mask);
            end else if (is_bios_page(pg)) begin
                res.route = ROUTE_BIOS;
                if (wr) res.dropped = 1'b1;
                else res.read_data = lane_read(bios_words[bios_cpu_index(a)], sh, mask);
            end else if (wr && nbytes == 4 && a == CACHE_CTRL_ADDR) begin
                res.route = ROUTE_CACHE;
                if (d == ISOLATE_A || d == ISOLATE_B) begin
                    if (!isolated) begin
                        isolated = 1'b1;
                        res.inval = 1'b1;
                    end
                end else if (d == RELEASE_A || d == RELEASE_B) begin
                    isolated = 1'b0;
                end
            end else begin
                res.route = ROUTE_NONE;
                if (wr) res.dropped = 1'b1;
            end
        end
        result_q.push_back(res);
    endfunction

    // A read of a BIOS word that was never loaded is turned into a dropped write.
    task automatic queue_access(input logic [1:0] cmd, size, input logic [31:0] address, data);
        logic [1:0] c;
        int unsigned idx;
        c = cmd;
        if (c == CMD_LOAD) begin
            idx = (address >> 2) & ((1 << ROM_WBITS) - 1);
            if (!bios_loaded.exists(idx)) begin
                bios_loaded[idx] = 1'b1;
                loaded_list.push_back(idx);
            end
        end else if (c != CMD_WRITE && is_bios_page(address[31:16])) begin
            if (!bios_loaded.exists(bios_cpu_index(address))) c = CMD_WRITE;
        end
        access_q.push_back('{cmd: c, size: size, address: address, data: data});
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got, want);
        $display("mismatch in %s at result %0d: got %h, want %h", field, results_seen, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        bus_access_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_result(s_cmd, s_access_size, s_address, s_write_data);
                sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (access_q.size() == 0 ||
                             ((popped == pause_a || popped == pause_b) &&
                              result_q.size() != 0)) begin
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 16);
                    s_valid <= 1'b0;
                end else begin
                    nxt = access_q.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= nxt.cmd;
                    s_access_size <= nxt.size;
                    s_address <= nxt.address;
                    s_write_data <= nxt.data;
                    popped++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        bus_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected transfer", m_read_data, 32'h0);
                end else begin
                    want = result_q.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", m_read_data, want.read_data);
                    if (m_route !== want.route)
                        report_mismatch("route", 32'(m_route), 32'(want.route));
                    if (m_write_dropped !== want.dropped)
                        report_mismatch("write_dropped", 32'(m_write_dropped),
                                        32'(want.dropped));
                    if (m_icache_invalidate !== want.inval)
                        report_mismatch("icache_invalidate", 32'(m_icache_invalidate),
                                        32'(want.inval));
                end
                results_seen++;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned ram_pool[RAM_POOL];
        int unsigned rom_pool[ROM_POOL];
        int unsigned k;
        int pick;
        logic [1:0]  c, z;
        logic [31:0] a, d;
        logic [15:0] pg, off;

        for (int i = 0; i < RAM_POOL; i++) ram_pool[i] = $urandom_range(0, (1 << RAM_WBITS) - 1);
        ram_pool[0] = 0;
        ram_pool[1] = (1 << RAM_WBITS) - 1;
        for (int i = 0; i < ROM_POOL; i++) rom_pool[i] = $urandom_range(0, (1 << ROM_WBITS) - 1);

        queue_access(CMD_LOAD,  SIZE_WORD, 32'h0000_0000, 32'hDEAD_BEEF);
        queue_access(CMD_LOAD,  SIZE_BYTE, 32'hFFFF_FFFF, 32'h8BAD_F00D);
        queue_access(CMD_READ,  SIZE_WORD, 32'h1FC0_0000, 32'h0);
        queue_access(CMD_READ,  SIZE_BYTE, 32'hBFC0_0003, 32'h0);
        queue_access(CMD_READ,  SIZE_HALF, 32'h9FC7_FFFE, 32'h0);
        queue_access(CMD_WRITE, SIZE_WORD, 32'h1FC0_0000, 32'hFFFF_FFFF);
        queue_access(CMD_WRITE, SIZE_WORD, 32'h0000_0000, 32'h1122_3344);
        queue_access(CMD_READ,  SIZE_BYTE, 32'h8000_0001, 32'h0);
        queue_access(CMD_READ,  SIZE_HALF, 32'hA000_0003, 32'h0);
        queue_access(CMD_WRITE, SIZE_WORD, 32'h001F_FFFC, 32'hFFFF_FFFF);
        queue_access(CMD_READ,  SIZE_WORD, 32'h807F_FFFC, 32'h0);
        queue_access(CMD_WRITE, SIZE_BYTE, 32'h1F80_03FF, 32'hFFFF_FFA5);
        queue_access(CMD_READ,  SIZE_WORD, 32'hBF80_03FC, 32'h0);
        queue_access(CMD_READ,  SIZE_WORD, 32'h1F80_0400, 32'h0);
        queue_access(CMD_WRITE, SIZE_HALF, 32'h9F80_FFFE, 32'h1234_5678);
        queue_access(CMD_WRITE, SIZE_HALF, 32'h1F00_FFFE, 32'h5555_CAFE);
        queue_access(CMD_READ,  SIZE_WORD, 32'h1F00_FFFC, 32'h0);
        queue_access(CMD_WRITE, SIZE_WORD, CACHE_CTRL_ADDR, ISOLATE_A);
        queue_access(CMD_WRITE, SIZE_WORD_ALT, 32'hFFFE_0133, ISOLATE_B);
        queue_access(CMD_WRITE, SIZE_WORD, 32'h0000_0000, 32'h0);
        queue_access(CMD_WRITE, SIZE_BYTE, CACHE_CTRL_ADDR, RELEASE_A);
        queue_access(CMD_READ,  SIZE_WORD, CACHE_CTRL_ADDR, 32'h0);
        queue_access(CMD_WRITE, SIZE_WORD, CACHE_CTRL_ADDR, 32'h1234_5678);
        queue_access(CMD_WRITE, SIZE_WORD, CACHE_CTRL_ADDR, RELEASE_B);
        queue_access(CMD_READ_ALT, SIZE_WORD_ALT, 32'h0000_0003, 32'h0);
        queue_access(CMD_WRITE, SIZE_WORD, 32'hFFFF_FFFC, 32'hA5A5_A5A5);
        queue_access(CMD_READ,  SIZE_BYTE, 32'hFFFF_FFFF, 32'h0);
        pause_a = access_q.size();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            z = 2'($urandom_range(0, 3));
            d = $urandom;
            c = $urandom_range(0, 1) ? CMD_WRITE
                : ($urandom_range(0, 7) == 0 ? CMD_READ_ALT : CMD_READ);
            if (pick < 25) begin
                a = (ram_pool[$urandom_range(0, RAM_POOL - 1)] << 2) | $urandom_range(0, 3);
                a = (a | ($urandom << RAM_ADDR_BITS)) & 32'h007F_FFFF;
                a[31:16] = a[31:16] | pick_page(16'h0000, PG_RAM1, PG_RAM2);
            end else if (pick < 40) begin
                off = $urandom_range(0, 1) ? 16'($urandom_range(0, 127))
                    : 16'($urandom_range(0, (1 << SCRATCH_ADDR_BITS) - 1));
                a = {pick_page(PG_SCR0, PG_SCR1, PG_SCR2), off};
            end else if (pick < 50) begin
                off = $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                    : 16'($urandom_range(0, 16'hFFFF));
                a = {PG_PAR, off};
            end else if (pick < 55) begin
                off = 16'($urandom_range(1 << SCRATCH_ADDR_BITS, 16'hFFFF));
                a = {pick_page(PG_SCR0, PG_SCR1, PG_SCR2), off};
            end else if (pick < 65) begin
                pg = pick_page(PG_BIOS0, PG_BIOS1, PG_BIOS2);
                if (pick < 62 && loaded_list.size() != 0) begin
                    k = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                    a = {pg, 16'h0} | (k << 2) | $urandom_range(0, 3);
                    if (c == CMD_WRITE) c = CMD_READ;
                end else begin
                    a = {pg | 16'($urandom_range(0, 7)), 16'($urandom)};
                    c = CMD_WRITE;
                end
            end else if (pick < 73) begin
                a = $urandom;
                a = (a & ~(((1 << ROM_WBITS) - 1) << 2)) |
                    (rom_pool[$urandom_range(0, ROM_POOL - 1)] << 2);
                c = CMD_LOAD;
            end else if (pick < 81) begin
                a = CACHE_CTRL_ADDR | $urandom_range(0, 3);
                if ($urandom_range(0, 9) < 8) begin
                    c = CMD_WRITE;
                    z = $urandom_range(0, 1) ? SIZE_WORD : SIZE_WORD_ALT;
                    case ($urandom_range(0, 4))
                        0: d = ISOLATE_A;
                        1: d = ISOLATE_B;
                        2: d = RELEASE_A;
                        3: d = RELEASE_B;
                        default: d = $urandom;
                    endcase
                end
            end else begin
                c = 2'($urandom_range(0, 3));
                a = $urandom;
            end
            queue_access(c, z, a, d);
        end
        pause_b = pause_a + RANDOM_ITEMS / 2;
        total_items = access_q.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (sent != total_items) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: console_bus_memory_map.f
sv/cbmm_pkg.sv
sv/cbmm_ram.sv
sv/cbmm_decode.sv
sv/console_bus_memory_map.sv
tb/testbench.sv
